[hdl/rfae_pkg.sv]
// Shared types and constants of the register file ALU executor.
`default_nettype none
package rfae_pkg;

  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;
  localparam int IMM_W     = 25;
  localparam int BYTE_W    = 8;
  localparam int ERR_W     = 2;
  localparam int CNT_W     = $clog2(DATA_W);

  typedef enum logic [2:0] {
    OP_CMOV,
    OP_ADD,
    OP_MUL,
    OP_DIV,
    OP_NAND,
    OP_LOADVAL,
    OP_OUTPUT,
    OP_INPUT
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE,
    ERR_DIV_ZERO,
    ERR_OUT_RANGE
  } err_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EXEC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic last;
  } alu_stat_t;

  typedef struct packed {
    logic                 wrote;
    logic [REG_IDX_W-1:0] write_index;
    logic [DATA_W-1:0]    write_value;
    logic                 out_valid;
    logic [BYTE_W-1:0]    out_byte;
    err_e                 error_code;
  } res_t;

endpackage
`default_nettype wire

[hdl/rfae_if.sv]
// Instruction and result channel interfaces.
`default_nettype none
interface rfae_in_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     mode;
  logic [rfae_pkg::REG_IDX_W-1:0] reg_a;
  logic [rfae_pkg::REG_IDX_W-1:0] reg_b;
  logic [rfae_pkg::REG_IDX_W-1:0] reg_c;
  logic [rfae_pkg::IMM_W-1:0]     load_value;
  logic [rfae_pkg::BYTE_W-1:0]    input_byte;
  logic                           input_end;

  modport source (output valid, mode, reg_a, reg_b, reg_c, load_value, input_byte,
                  input_end, input ready);
  modport sink (input valid, mode, reg_a, reg_b, reg_c, load_value, input_byte,
                input_end, output ready);
endinterface

interface rfae_out_if;
  logic                           valid;
  logic                           ready;
  logic                           wrote;
  logic [rfae_pkg::REG_IDX_W-1:0] write_index;
  logic [rfae_pkg::DATA_W-1:0]    write_value;
  logic                           out_valid;
  logic [rfae_pkg::BYTE_W-1:0]    out_byte;
  logic [rfae_pkg::ERR_W-1:0]     error_code;

  modport source (output valid, wrote, write_index, write_value, out_valid, out_byte,
                  error_code, input ready);
  modport sink (input valid, wrote, write_index, write_value, out_valid, out_byte,
                error_code, output ready);
endinterface
`default_nettype wire

[hdl/rfae_regfile.sv]
// Register file: storage array, per-entry valid bits, two registered read ports.
`default_nettype none
module rfae_regfile #(
  parameter int NUM_REGS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           rd_en_i,
  input  wire logic [rfae_pkg::REG_IDX_W-1:0] rd_b_idx_i,
  input  wire logic [rfae_pkg::REG_IDX_W-1:0] rd_c_idx_i,
  output      logic [rfae_pkg::DATA_W-1:0]    rd_b_o,
  output      logic [rfae_pkg::DATA_W-1:0]    rd_c_o,
  input  wire logic                           we_i,
  input  wire logic [rfae_pkg::REG_IDX_W-1:0] wr_idx_i,
  input  wire logic [rfae_pkg::DATA_W-1:0]    wr_data_i
);

  localparam int AW = $clog2(NUM_REGS);

  logic [rfae_pkg::DATA_W-1:0] mem_q [NUM_REGS];
  logic [NUM_REGS-1:0]         vld_q;
  logic [rfae_pkg::DATA_W-1:0] rdb_q, rdc_q;
  logic                        rdb_ok_q, rdc_ok_q;

  logic [AW-1:0] b_addr, c_addr, w_addr;
  logic          b_in, c_in;

  assign b_addr = rd_b_idx_i[AW-1:0];
  assign c_addr = rd_c_idx_i[AW-1:0];
  assign w_addr = wr_idx_i[AW-1:0];
  assign b_in   = rd_b_idx_i < NUM_REGS;
  assign c_in   = rd_c_idx_i < NUM_REGS;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[w_addr] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[w_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdb_q <= mem_q[b_addr];
      rdc_q <= mem_q[c_addr];
    end
  end

  // never-written or out-of-range entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdb_ok_q <= 1'b0;
      rdc_ok_q <= 1'b0;
    end else if (rd_en_i) begin
      rdb_ok_q <= b_in && vld_q[b_addr];
      rdc_ok_q <= c_in && vld_q[c_addr];
    end
  end

  assign rd_b_o = rdb_ok_q ? rdb_q : '0;
  assign rd_c_o = rdc_ok_q ? rdc_q : '0;

endmodule
`default_nettype wire

[hdl/rfae_serial_alu.sv]
// Bit-serial ALU: serial add and nand, shift-add multiply, restoring divide.
`default_nettype none
module rfae_serial_alu (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rfae_pkg::alu_ctrl_t         ctrl_i,
  input  wire logic [rfae_pkg::DATA_W-1:0] opb_i,
  input  wire logic [rfae_pkg::DATA_W-1:0] opc_i,
  output      logic [rfae_pkg::DATA_W-1:0] result_o,
  output      rfae_pkg::alu_stat_t         stat_o
);

  localparam int W = rfae_pkg::DATA_W;

  rfae_pkg::op_e               op_q;
  logic [W-1:0]                acc_q, opb_q, opc_q;
  logic                        carry_q;
  logic [rfae_pkg::CNT_W-1:0]  cnt_q;
  logic                        busy_q;
  logic                        last;

  // shared adder: acc + b for multiply, partial remainder - divisor for divide
  logic         is_div;
  logic [W:0]   add_x, add_y;
  logic [W+1:0] add_sum;
  logic         sum_bit, carry_d, nand_bit;

  assign is_div  = op_q == rfae_pkg::OP_DIV;
  assign add_x   = is_div ? {acc_q, opb_q[W-1]} : {1'b0, acc_q};
  assign add_y   = is_div ? ~{1'b0, opc_q} : {1'b0, opb_q};
  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, is_div};

  assign sum_bit  = opb_q[0] ^ opc_q[0] ^ carry_q;
  assign carry_d  = (opb_q[0] & opc_q[0]) | (carry_q & (opb_q[0] ^ opc_q[0]));
  assign nand_bit = ~(opb_q[0] & opc_q[0]);

  assign last = busy_q && (cnt_q == rfae_pkg::CNT_W'(W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      op_q    <= ctrl_i.op;
      acc_q   <= '0;
      opb_q   <= opb_i;
      opc_q   <= opc_i;
      carry_q <= 1'b0;
    end else if (busy_q) begin
      case (op_q)
        rfae_pkg::OP_ADD: begin
          acc_q   <= {sum_bit, acc_q[W-1:1]};
          carry_q <= carry_d;
          opb_q   <= {1'b0, opb_q[W-1:1]};
          opc_q   <= {1'b0, opc_q[W-1:1]};
        end
        rfae_pkg::OP_NAND: begin
          acc_q <= {nand_bit, acc_q[W-1:1]};
          opb_q <= {1'b0, opb_q[W-1:1]};
          opc_q <= {1'b0, opc_q[W-1:1]};
        end
        rfae_pkg::OP_MUL: begin
          if (opc_q[0]) begin
            acc_q <= add_sum[W-1:0];
          end
          opb_q <= {opb_q[W-2:0], 1'b0};
          opc_q <= {1'b0, opc_q[W-1:1]};
        end
        rfae_pkg::OP_DIV: begin
          // carry out set means no borrow: quotient bit is one
          acc_q <= add_sum[W+1] ? add_sum[W-1:0] : add_x[W-1:0];
          opb_q <= {opb_q[W-2:0], add_sum[W+1]};
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  assign result_o    = is_div ? opb_q : acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.last = last;

endmodule
`default_nettype wire

[hdl/register_file_alu_executor.sv]
// Top level: instruction sequencer, result formation and output register.
//
// Executes one decoded instruction per transaction against a NUM_REGS x 32-bit
// register file that reads as zero after reset (per-entry valid bits, no
// clearing pass). Add, multiply, divide and nand run through a bit-serial ALU
// one bit per cycle. For these the sequencer accepts the instruction and
// issues the registered register read, loads the operands into the ALU, runs
// the 32-step loop of the serial ALU and then forms the result. Conditional
// move, load value, output and input skip the serial loop and go straight
// to result formation. Each instruction yields one result
// transaction; a pending result stalls the sequencer only when the next
// result is ready before the previous one has been taken. Register writes
// land when the result is loaded into the output register, so a following
// instruction always sees them. Writes to indices at or beyond NUM_REGS are
// dropped and reported as no write.
`default_nettype none
module register_file_alu_executor #(
  parameter int NUM_REGS = 8
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  rfae_in_if.sink   in_i,
  rfae_out_if.source out_o
);

  localparam int W  = rfae_pkg::DATA_W;
  localparam int IW = rfae_pkg::REG_IDX_W;

  rfae_pkg::state_e state_q, state_d;

  // captured instruction
  rfae_pkg::op_e                mode_q;
  logic [IW-1:0]                ra_q, rc_q;
  logic [rfae_pkg::IMM_W-1:0]   imm_q;
  logic [rfae_pkg::BYTE_W-1:0]  ib_q;
  logic                         iend_q;

  logic                         in_fire;
  logic                         in_ready;
  logic                         done_fire;
  logic                         serial_op;

  logic [W-1:0]                 vb, vc, alu_res;
  rfae_pkg::alu_ctrl_t          alu_ctrl;
  rfae_pkg::alu_stat_t          alu_stat;

  logic                         out_vld_q;
  rfae_pkg::res_t               out_q, res;

  // raw result before the range check on the destination
  logic                         wr_req;
  logic [IW-1:0]                wr_idx;
  logic [W-1:0]                 wr_val;
  logic                         wr_ok;
  logic                         rf_we;

  assign in_fire = in_i.valid && in_i.ready;

  rfae_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire),
    .rd_b_idx_i (in_i.reg_b),
    .rd_c_idx_i (in_i.reg_c),
    .rd_b_o     (vb),
    .rd_c_o     (vc),
    .we_i       (rf_we),
    .wr_idx_i   (wr_idx),
    .wr_data_i  (wr_val)
  );

  rfae_serial_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (alu_ctrl),
    .opb_i    (vb),
    .opc_i    (vc),
    .result_o (alu_res),
    .stat_o   (alu_stat)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= rfae_pkg::op_e'(in_i.mode);
      ra_q   <= in_i.reg_a;
      rc_q   <= in_i.reg_c;
      imm_q  <= in_i.load_value;
      ib_q   <= in_i.input_byte;
      iend_q <= in_i.input_end;
    end
  end

  always_comb begin
    unique case (mode_q) inside
      rfae_pkg::OP_ADD, rfae_pkg::OP_MUL, rfae_pkg::OP_DIV, rfae_pkg::OP_NAND: begin
        serial_op = 1'b1;
      end
      default: begin
        serial_op = 1'b0;
      end
    endcase
  end

  // ---- sequencer: next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfae_pkg::S_IDLE: begin
        if (in_fire) state_d = rfae_pkg::S_LOAD;
      end
      rfae_pkg::S_LOAD: begin
        state_d = serial_op ? rfae_pkg::S_EXEC : rfae_pkg::S_DONE;
      end
      rfae_pkg::S_EXEC: begin
        if (alu_stat.last) state_d = rfae_pkg::S_DONE;
      end
      rfae_pkg::S_DONE: begin
        if (done_fire) state_d = rfae_pkg::S_IDLE;
      end
      default: begin
        state_d = rfae_pkg::S_IDLE;
      end
    endcase
  end

  // ---- sequencer: outputs ----
  always_comb begin
    in_ready       = 1'b0;
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = mode_q;
    done_fire      = 1'b0;
    unique case (state_q)
      rfae_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      rfae_pkg::S_LOAD: begin
        alu_ctrl.start = serial_op;
      end
      rfae_pkg::S_EXEC: begin
        in_ready = 1'b0;
      end
      rfae_pkg::S_DONE: begin
        // output register free, or being emptied this cycle
        done_fire = !out_vld_q || out_o.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfae_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_i.ready = in_ready;

  // ---- result formation ----
  always_comb begin
    wr_req         = 1'b0;
    wr_idx         = ra_q;
    wr_val         = alu_res;
    res.out_valid  = 1'b0;
    res.out_byte   = '0;
    res.error_code = rfae_pkg::ERR_NONE;
    unique case (mode_q) inside
      rfae_pkg::OP_CMOV: begin
        wr_req = vc != '0;
        wr_val = vb;
      end
      rfae_pkg::OP_ADD, rfae_pkg::OP_MUL, rfae_pkg::OP_NAND: begin
        wr_req = 1'b1;
      end
      rfae_pkg::OP_DIV: begin
        if (vc == '0) begin
          res.error_code = rfae_pkg::ERR_DIV_ZERO;
        end else begin
          wr_req = 1'b1;
        end
      end
      rfae_pkg::OP_LOADVAL: begin
        wr_req = 1'b1;
        wr_val = {{(W - rfae_pkg::IMM_W){1'b0}}, imm_q};
      end
      rfae_pkg::OP_OUTPUT: begin
        if (vc[W-1:rfae_pkg::BYTE_W] != '0) begin
          res.error_code = rfae_pkg::ERR_OUT_RANGE;
        end else begin
          res.out_valid = 1'b1;
          res.out_byte  = vc[rfae_pkg::BYTE_W-1:0];
        end
      end
      rfae_pkg::OP_INPUT: begin
        wr_req = 1'b1;
        wr_idx = rc_q;
        wr_val = iend_q ? '1 : {{(W - rfae_pkg::BYTE_W){1'b0}}, ib_q};
      end
      default: begin
        wr_req = 1'b0;
      end
    endcase
    wr_ok           = wr_req && (wr_idx < NUM_REGS);
    res.wrote       = wr_ok;
    res.write_index = wr_ok ? wr_idx : '0;
    res.write_value = wr_ok ? wr_val : '0;
  end

  assign rf_we = done_fire && wr_ok;

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (done_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.wrote       = out_q.wrote;
  assign out_o.write_index = out_q.write_index;
  assign out_o.write_value = out_q.write_value;
  assign out_o.out_valid   = out_q.out_valid;
  assign out_o.out_byte    = out_q.out_byte;
  assign out_o.error_code  = out_q.error_code;

  // ---- assertions ----
  a_exec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rfae_pkg::S_EXEC |-> alu_stat.busy)
    else $error("sequencer in execute while serial ALU is idle");

  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == rfae_pkg::S_LOAD)
    else $error("accepted instruction did not start register read");

  a_we_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (wr_idx < NUM_REGS))
    else $error("register write beyond register count");

  a_err_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.wrote && (out_o.error_code != rfae_pkg::ERR_NONE)))
    else $error("result reports both a write and an error");

  a_write_xor_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.wrote && out_o.out_valid))
    else $error("result reports both a write and an output byte");

endmodule
`default_nettype wire
